### hdl/gcald_pkg.sv
// Shared types and constants for the glyph cache directory.
package gcald_pkg;

  // Field widths fixed by the interface
  localparam int ACT_W  = 2;
  localparam int CODE_W = 21;
  localparam int STAT_W = 3;
  localparam int SLOT_W = 11;
  localparam int CFG_W  = 4;
  localparam int TAG_W  = 21;
  localparam int AGE_W  = 16;

  // Request codes
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TICK   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  // Result codes
  localparam logic [STAT_W-1:0] STAT_HIT     = 3'd0;
  localparam logic [STAT_W-1:0] STAT_INSTALL = 3'd1;
  localparam logic [STAT_W-1:0] STAT_RESIZE  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FLUSH   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_DONE    = 3'd4;

  // Age constants
  localparam logic [AGE_W-1:0] AGE_RESET    = 16'd1;
  localparam logic [AGE_W-1:0] AGE_LAST     = 16'hFFFF;
  localparam logic [AGE_W-1:0] AGE_RENORM   = 16'd16385;
  localparam logic [AGE_W-1:0] RECENT_LIMIT = 16'd500;

  localparam logic [CFG_W-1:0] INDEX_BITS_RESET = 4'd6;

  // One directory entry; age zero marks it empty
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } entry_t;

  // Window scan summary
  typedef struct packed {
    logic             hit;
    logic [AGE_W-1:0] min_age;
  } scan_t;

endpackage

### hdl/glyph_cache_age_lru_directory_top.sv
// Top level of the glyph cache directory: control sequencer around the slot memory.
//
// Requests enter on start/action/char_code and are taken when start is high
// and busy is low. Each request gives exactly one result on status/slot,
// marked by a one-cycle done strobe; the receiver cannot stall it.
// Slot tag and age share one memory of 2^MAX_INDEX_BITS + WINDOW entries.
// A lookup reads its window one entry per cycle through the memory read
// port, then decides and writes back; busy drops in the done cycle so the
// next request may follow. A tick only advances the age counter, except
// when the counter wraps: then every slot is read, renormalized and written
// back. A clear writes every slot empty. After reset the same clearing pass
// runs with busy high and no done strobe; index_bits may be written meanwhile.
// index_bits is written by cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce.
module glyph_cache_age_lru_directory_top #(
  parameter int WINDOW         = 5,
  parameter int MAX_INDEX_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [gcald_pkg::ACT_W-1:0]  action,
  input  logic [gcald_pkg::CODE_W-1:0] char_code,
  output logic                         done,
  output logic [gcald_pkg::STAT_W-1:0] status,
  output logic [gcald_pkg::SLOT_W-1:0] slot,
  input  logic                         cfg_we,
  input  logic [gcald_pkg::CFG_W-1:0]  cfg_wdata
);
  import gcald_pkg::*;

  localparam int SLOT_COUNT = (1 << MAX_INDEX_BITS) + WINDOW;
  localparam int AW         = $clog2(SLOT_COUNT);
  localparam int CW         = $clog2(SLOT_COUNT + 1);
  localparam int OW         = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int MW         = MAX_INDEX_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOK   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SWEEP  = 3'd3;
  localparam logic [2:0] S_NORM   = 3'd4;

  logic [2:0]        state;
  logic [CW-1:0]     cnt;
  logic [CODE_W-1:0] code;
  logic [AW-1:0]     base;
  logic [AGE_W-1:0]  cur_age;
  logic [CFG_W-1:0]  index_bits;
  logic              emit;
  logic              rvalid;
  logic [OW-1:0]     roff;
  logic              norm_valid;
  logic [AW-1:0]     norm_addr;

  logic              we;
  logic [AW-1:0]     waddr;
  entry_t            wdata;
  logic [AW-1:0]     raddr;
  entry_t            rdata;

  scan_t             summary;
  logic [OW-1:0]     hit_off;
  logic [OW-1:0]     min_off;

  logic [4:0]        eff_bits;
  logic [MW-1:0]     mask;
  logic [CODE_W-1:0] hash;
  logic [AW-1:0]     hash_base;
  logic              issue_look;
  logic              issue_norm;
  logic [AW-1:0]     hit_addr;
  logic [AW-1:0]     victim_addr;
  logic [AGE_W:0]    age_diff;
  logic              want_resize;
  logic              want_flush;
  logic [AW+SLOT_W-1:0] hit_ext;
  logic [AW+SLOT_W-1:0] victim_ext;

  assign busy = (state != S_IDLE);

  // hash: 17*code masked to the active set count
  always_comb begin
    eff_bits  = ({1'b0, index_bits} > 5'(MW)) ? 5'(MW) : {1'b0, index_bits};
    mask      = ~({MW{1'b1}} << eff_bits);
    hash      = char_code + (char_code << 4);
    hash_base = AW'(hash[MW-1:0] & mask);
  end

  // read issue
  assign issue_look = (state == S_LOOK) && (cnt < CW'(WINDOW));
  assign issue_norm = (state == S_NORM) && (cnt < CW'(SLOT_COUNT));

  always_comb begin
    raddr = (state == S_NORM) ? AW'(cnt) : (base + AW'(cnt));
  end

  // miss decision from the scan summary
  always_comb begin
    hit_addr    = base + AW'(hit_off);
    victim_addr = base + AW'(min_off);
    hit_ext     = {{SLOT_W{1'b0}}, hit_addr};
    victim_ext  = {{SLOT_W{1'b0}}, victim_addr};
    age_diff    = {1'b0, cur_age} - {1'b0, summary.min_age};
    want_resize = (summary.min_age != '0) && !age_diff[AGE_W] &&
                  (age_diff[AGE_W-1:0] < RECENT_LIMIT) && (eff_bits < 5'(MW));
    want_flush  = (summary.min_age == cur_age);
  end

  // write port
  always_comb begin
    we        = 1'b0;
    waddr     = AW'(cnt);
    wdata.tag = code;
    wdata.age = cur_age;
    case (state)
      S_DECIDE: begin
        if (summary.hit) begin
          we    = 1'b1;
          waddr = hit_addr;
        end else if (!want_resize && !want_flush) begin
          we    = 1'b1;
          waddr = victim_addr;
        end
      end
      S_SWEEP: begin
        we        = 1'b1;
        wdata.tag = '0;
        wdata.age = '0;
      end
      S_NORM: begin
        we        = norm_valid;
        waddr     = norm_addr;
        wdata.tag = rdata.tag;
        wdata.age = (rdata.age != '0) ? ((rdata.age >> 2) + AGE_W'(1)) : '0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // read pipeline tags
  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid     <= 1'b0;
      norm_valid <= 1'b0;
    end else begin
      rvalid     <= issue_look;
      norm_valid <= issue_norm;
    end
    roff      <= OW'(cnt);
    norm_addr <= AW'(cnt);
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits <= INDEX_BITS_RESET;
    end else if (cfg_we) begin
      index_bits <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_SWEEP;
      cnt     <= '0;
      emit    <= 1'b0;
      cur_age <= AGE_RESET;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cnt    <= '0;
            status <= STAT_DONE;
            slot   <= '0;
            case (action)
              ACT_LOOKUP: begin
                code  <= char_code;
                base  <= hash_base;
                state <= S_LOOK;
              end
              ACT_TICK: begin
                if (cur_age == AGE_LAST) begin
                  cur_age <= AGE_RENORM;
                  state   <= S_NORM;
                end else begin
                  cur_age <= cur_age + AGE_W'(1);
                  done    <= 1'b1;
                end
              end
              ACT_CLEAR: begin
                emit  <= 1'b1;
                state <= S_SWEEP;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_LOOK: begin
          if (issue_look) begin
            cnt <= cnt + CW'(1);
          end
          if (rvalid && (roff == OW'(WINDOW - 1))) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (summary.hit) begin
            status <= STAT_HIT;
            slot   <= hit_ext[SLOT_W-1:0];
          end else if (want_resize) begin
            status <= STAT_RESIZE;
            slot   <= '0;
          end else if (want_flush) begin
            status <= STAT_FLUSH;
            slot   <= '0;
          end else begin
            status <= STAT_INSTALL;
            slot   <= victim_ext[SLOT_W-1:0];
          end
        end
        S_SWEEP: begin
          if (cnt == CW'(SLOT_COUNT - 1)) begin
            done   <= emit;
            status <= STAT_DONE;
            slot   <= '0;
            state  <= S_IDLE;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_NORM: begin
          if (issue_norm) begin
            cnt <= cnt + CW'(1);
          end
          if (norm_valid && (norm_addr == AW'(SLOT_COUNT - 1))) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  gcald_ram #(
    .DEPTH (SLOT_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  gcald_scan #(
    .OW (OW)
  ) u_scan (
    .clk     (clk),
    .en      (rvalid),
    .first   (roff == '0),
    .off     (roff),
    .code    (code),
    .rd      (rdata),
    .summary (summary),
    .hit_off (hit_off),
    .min_off (min_off)
  );

endmodule

### hdl/gcald_ram.sv
// Simple dual-port directory memory, one write and one registered read per cycle.
module gcald_ram #(
  parameter int DEPTH = 1029,
  parameter int AW    = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  gcald_pkg::entry_t wdata,
  input  logic [AW-1:0]     raddr,
  output gcald_pkg::entry_t rdata
);
  import gcald_pkg::*;

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/gcald_scan.sv
// Window scan: finds the first tag hit and the oldest entry, one entry per cycle while en is high.
module gcald_scan #(
  parameter int OW = 3
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        first,
  input  logic [OW-1:0]               off,
  input  logic [gcald_pkg::CODE_W-1:0] code,
  input  gcald_pkg::entry_t           rd,
  output gcald_pkg::scan_t            summary,
  output logic [OW-1:0]               hit_off,
  output logic [OW-1:0]               min_off
);
  import gcald_pkg::*;

  logic match;

  // live entry with the requested tag
  assign match = (rd.age != '0) && (rd.tag == code);

  // first hit wins; strict compare keeps the first of equal ages
  always_ff @(posedge clk) begin
    if (en) begin
      if (first) begin
        summary.hit     <= match;
        hit_off         <= off;
        summary.min_age <= rd.age;
        min_off         <= off;
      end else begin
        if (!summary.hit && match) begin
          summary.hit <= 1'b1;
          hit_off     <= off;
        end
        if (rd.age < summary.min_age) begin
          summary.min_age <= rd.age;
          min_off         <= off;
        end
      end
    end
  end

endmodule
